### rtl/weip_pkg.sv
`default_nettype none
package weip_pkg;

  localparam int unsigned HIST_DEPTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CLASS_W   = 16;
  localparam int unsigned IVL_W     = 33;
  localparam int unsigned FAULT_W   = 2;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ENTRY_W   = TIME_W + KIND_W;

  localparam int unsigned KIND_REF = 0;
  localparam int unsigned KIND_TGT = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_CLASS    = 2'd0,
    CFG_TARGET_CLASS = 2'd1,
    CFG_HALF_WINDOW  = 2'd2
  } cfg_idx_e;

  typedef logic [KIND_W-1:0] kind_t;

  // one event handed from the classifier to the history walker
  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    kind_t             kind;
    logic              train_end;
    logic              order_fault;
  } qitem_t;

  typedef struct packed {
    logic signed [IVL_W-1:0] interval;
    logic                    run_last;
    logic [FAULT_W-1:0]      fault;
  } result_t;

endpackage
`default_nettype wire

### rtl/weip_if.sv
`default_nettype none
interface weip_evt_if;
  import weip_pkg::*;
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  event_time;
  logic [CLASS_W-1:0] event_class;
  logic               train_end;

  modport source (output valid, event_time, event_class, train_end, input ready);
  modport sink   (input valid, event_time, event_class, train_end, output ready);
endinterface

interface weip_res_if;
  import weip_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [IVL_W-1:0] interval;
  logic                    run_last;
  logic [FAULT_W-1:0]      fault;

  modport source (output valid, interval, run_last, fault, input ready);
  modport sink   (input valid, interval, run_last, fault, output ready);
endinterface
`default_nettype wire

### rtl/windowed_event_interval_pairs_core.sv
// Windowed event interval pairs.
// Events arrive on evt_i (valid/ready): timestamp, class id and a train end
// flag. Results leave on res_o (valid/ready): one signed 33-bit interval per
// reference/target pair within half_window ticks, run_last on the final one
// caused by an event, and the sticky fault bits as they stand after it.
// Registers (ref_class, target_class, half_window) are written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only while no
// event is in flight, and the block itself does not enforce it. A classifier
// takes an event per cycle into a four-entry queue while that queue has room;
// a walker then reads the history memory once per entry, newest first. An
// event that pairs passes an idle step, an evict step once the history is
// full, a walk step per visited entry (two for an entry that yields two
// intervals) and a finish step, paced by the single read port of the history
// memory. Events of other classes or with backward timestamps are not queued
// unless they end a train, and produce nothing. Reset clears the registers,
// the fill count, the head pointer and the faults; history contents need no
// clearing. A stalled receiver holds the output register; the walker stops
// behind it and the queue then fills and drops evt_i.ready.
`default_nettype none
module windowed_event_interval_pairs_core #(
  parameter int unsigned HISTORY_DEPTH = weip_pkg::HIST_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  weip_evt_if.sink                       evt_i,
  weip_res_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [weip_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [weip_pkg::CFG_W-1:0]     cfg_data_i
);
  import weip_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic [CLASS_W-1:0] ref_class_q;
  logic [CLASS_W-1:0] target_class_q;
  logic [TIME_W-1:0]  half_window_q;

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  qitem_t             q_in;
  qitem_t             q_out;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_class_q    <= '0;
      target_class_q <= '0;
      half_window_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_REF_CLASS:    ref_class_q    <= cfg_data_i[CLASS_W-1:0];
        CFG_TARGET_CLASS: target_class_q <= cfg_data_i[CLASS_W-1:0];
        CFG_HALF_WINDOW:  half_window_q  <= cfg_data_i[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  weip_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .evt            (evt_i),
    .ref_class_i    (ref_class_q),
    .target_class_i (target_class_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_in)
  );

  weip_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_item_o  (q_out),
    .empty_o     (q_empty)
  );

  weip_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_item_i      (q_out),
    .q_pop_o       (q_pop),
    .half_window_i (half_window_q),
    .res           (res_o),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  weip_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("event queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("event queue underflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (q_full && !q_pop) |=> !evt_i.ready)
    else $error("events taken while queue is full");

endmodule
`default_nettype wire

### rtl/weip_ram.sv
`default_nettype none
module weip_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/weip_queue.sv
`default_nettype none
module weip_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  weip_pkg::qitem_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output weip_pkg::qitem_t pop_item_o,
  output logic             empty_o
);
  import weip_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  qitem_t        slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wp_q;
  logic [PW-1:0] rp_q;
  logic [CW-1:0] cnt_q;

  assign full_o     = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/weip_front.sv
`default_nettype none
module weip_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  weip_evt_if.sink                     evt,
  input  logic [weip_pkg::CLASS_W-1:0] ref_class_i,
  input  logic [weip_pkg::CLASS_W-1:0] target_class_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output weip_pkg::qitem_t             q_item_o
);
  import weip_pkg::*;

  logic [TIME_W-1:0] newest_q;
  logic              order_fault_q;
  logic              accept;
  logic              backward;
  kind_t             kind;

  assign evt.ready = !q_full_i;
  assign accept    = evt.valid && evt.ready;
  assign backward  = (evt.event_time < newest_q);

  always_comb begin
    kind           = '0;
    kind[KIND_REF] = (evt.event_class == ref_class_i);
    kind[KIND_TGT] = (evt.event_class == target_class_i);
  end

  assign q_item_o.ev_time     = evt.event_time;
  assign q_item_o.kind        = backward ? '0 : kind;
  assign q_item_o.train_end   = evt.train_end;
  assign q_item_o.order_fault = order_fault_q || backward;

  // forward only what touches the history: relevant events and train ends
  assign q_push_o = accept && (evt.train_end || (!backward && (kind != '0)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q      <= '0;
      order_fault_q <= 1'b0;
    end else if (accept) begin
      if (evt.train_end) begin
        newest_q      <= '0;
        order_fault_q <= 1'b0;
      end else if (backward) begin
        order_fault_q <= 1'b1;
      end else begin
        newest_q <= evt.event_time;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/weip_back.sv
`default_nettype none
module weip_back #(
  parameter int unsigned HISTORY_DEPTH = weip_pkg::HIST_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_empty_i,
  input  weip_pkg::qitem_t                     q_item_i,
  output logic                                 q_pop_o,
  input  logic [weip_pkg::TIME_W-1:0]          half_window_i,
  weip_res_if.source                           res,
  output logic                                 ram_we_o,
  output logic [$clog2(HISTORY_DEPTH)-1:0]     ram_waddr_o,
  output logic [weip_pkg::ENTRY_W-1:0]         ram_wdata_o,
  output logic                                 ram_re_o,
  output logic [$clog2(HISTORY_DEPTH)-1:0]     ram_raddr_o,
  input  logic [weip_pkg::ENTRY_W-1:0]         ram_rdata_i
);
  import weip_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [1:0] {
    B_IDLE,
    B_EVICT,
    B_WALK,
    B_FIN
  } state_e;

  state_e             state_q;
  qitem_t             item_q;
  logic [AW-1:0]      head_q;
  logic [FW-1:0]      fill_q;
  logic [AW-1:0]      rp_q;
  logic [FW-1:0]      k_q;
  logic               ph_q;
  logic               lost_q;
  logic               pend_v_q;
  logic [IVL_W-1:0]   pend_q;
  logic               out_v_q;
  result_t            out_q;

  logic [TIME_W-1:0]  rd_time;
  kind_t              rd_kind;
  logic [TIME_W-1:0]  age;
  logic               in_win;
  logic [IVL_W-1:0]   diff_a;
  logic [IVL_W-1:0]   diff_b;
  logic               use_a;
  logic               use_b;
  logic               cur_has;
  logic [IVL_W-1:0]   cur_val;
  logic               ent_done;
  logic               out_free;
  logic               push_ok;
  logic               next_last;
  logic               full;
  logic [AW-1:0]      head_dec;
  logic [AW-1:0]      head_inc;
  logic [AW-1:0]      rp_dec;
  logic               walk_adv;
  logic               commit;
  logic [FAULT_W-1:0] fault_now;

  assign rd_time   = ram_rdata_i[TIME_W-1:0];
  assign rd_kind   = ram_rdata_i[ENTRY_W-1:TIME_W];
  assign age       = item_q.ev_time - rd_time;
  assign in_win    = (age <= half_window_i);
  assign diff_a    = {1'b0, item_q.ev_time} - {1'b0, rd_time};
  assign diff_b    = {1'b0, rd_time} - {1'b0, item_q.ev_time};
  assign use_a     = rd_kind[KIND_REF] && item_q.kind[KIND_TGT];
  assign use_b     = item_q.kind[KIND_REF] && rd_kind[KIND_TGT];

  // second phase of an entry carries the new-reference interval only
  assign cur_has   = ph_q || use_a || use_b;
  assign cur_val   = (ph_q || !use_a) ? diff_b : diff_a;
  assign ent_done  = ph_q || !(use_a && use_b);

  assign out_free  = !out_v_q || res.ready;
  assign push_ok   = !pend_v_q || out_free;
  assign next_last = ((k_q + FW'(1)) == fill_q);
  assign full      = (fill_q == FW'(HISTORY_DEPTH));
  assign head_dec  = (head_q == '0) ? AW'(HISTORY_DEPTH - 1) : head_q - AW'(1);
  assign head_inc  = (head_q == AW'(HISTORY_DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign rp_dec    = (rp_q == '0) ? AW'(HISTORY_DEPTH - 1) : rp_q - AW'(1);
  assign walk_adv  = in_win && (!cur_has || push_ok) && ent_done;
  assign commit    = !pend_v_q || out_free;
  assign fault_now = {item_q.order_fault, lost_q};

  assign q_pop_o   = (state_q == B_IDLE) && !q_empty_i;

  always_comb begin
    ram_re_o    = 1'b0;
    ram_raddr_o = head_dec;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i && (q_item_i.kind != '0) && (fill_q != '0)) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = full ? head_q : head_dec;
        end
      end
      B_EVICT: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = head_dec;
      end
      B_WALK: begin
        ram_re_o    = walk_adv && !next_last;
        ram_raddr_o = rp_dec;
      end
      default: begin
        ram_re_o = 1'b0;
      end
    endcase
  end

  assign ram_we_o    = (state_q == B_FIN) && commit && (item_q.kind != '0);
  assign ram_waddr_o = head_q;
  assign ram_wdata_o = {item_q.kind, item_q.ev_time};

  assign res.valid    = out_v_q;
  assign res.interval = out_q.interval;
  assign res.run_last = out_q.run_last;
  assign res.fault    = out_q.fault;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      head_q   <= '0;
      fill_q   <= '0;
      rp_q     <= '0;
      k_q      <= '0;
      ph_q     <= 1'b0;
      lost_q   <= 1'b0;
      pend_v_q <= 1'b0;
      pend_q   <= '0;
      out_v_q  <= 1'b0;
      out_q    <= '0;
    end else begin
      if (out_v_q && res.ready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            k_q  <= '0;
            ph_q <= 1'b0;
            rp_q <= head_dec;
            if ((q_item_i.kind == '0) || (fill_q == '0)) begin
              state_q <= B_FIN;
            end else if (full) begin
              state_q <= B_EVICT;
            end else begin
              state_q <= B_WALK;
            end
          end
        end
        B_EVICT: begin
          // oldest entry is about to be overwritten while still in reach
          if (in_win) begin
            lost_q <= 1'b1;
          end
          state_q <= B_WALK;
        end
        B_WALK: begin
          if (!in_win) begin
            state_q <= B_FIN;
          end else if (!cur_has || push_ok) begin
            // hold one result back so the last one can be flagged
            if (cur_has) begin
              if (pend_v_q) begin
                out_q   <= '{interval: pend_q, run_last: 1'b0, fault: fault_now};
                out_v_q <= 1'b1;
              end
              pend_q   <= cur_val;
              pend_v_q <= 1'b1;
            end
            if (ent_done) begin
              ph_q <= 1'b0;
              k_q  <= k_q + FW'(1);
              rp_q <= rp_dec;
              if (next_last) begin
                state_q <= B_FIN;
              end
            end else begin
              ph_q <= 1'b1;
            end
          end
        end
        B_FIN: begin
          if (commit) begin
            if (pend_v_q) begin
              out_q    <= '{interval: pend_q, run_last: 1'b1, fault: fault_now};
              out_v_q  <= 1'b1;
              pend_v_q <= 1'b0;
            end
            if (item_q.kind != '0) begin
              head_q <= head_inc;
              if (!full) begin
                fill_q <= fill_q + FW'(1);
              end
            end
            if (item_q.train_end) begin
              head_q <= '0;
              fill_q <= '0;
              lost_q <= 1'b0;
            end
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### bench/tb_windowed_event_interval_pairs_core.sv
`timescale 1ns / 100ps
module tb_windowed_event_interval_pairs_core;
  import weip_pkg::*;

  localparam int unsigned DEPTH         = HIST_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = (QUEUE_DEPTH + 1) * (2 * DEPTH + 3) + 16;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int          PREDICTED     = -1;
  localparam int          RAND_PHASES   = 8;
  localparam int          PHASE_ITEMS   = 25;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef enum logic {ROW_CFG, ROW_EVT} row_op_e;

  typedef struct {
    row_op_e                 op;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_W-1:0]        value;
    logic [CLASS_W-1:0]      cls;
    logic                    end_flag;
    int                      typed_n;
    logic signed [IVL_W-1:0] typed_ivl;
    logic [FAULT_W-1:0]      typed_fault;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  weip_evt_if evt_if ();
  weip_res_if res_if ();

  windowed_event_interval_pairs_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the block's registers and pairing history
  logic [CLASS_W-1:0] cfg_ref;
  logic [CLASS_W-1:0] cfg_tgt;
  logic [TIME_W-1:0]  cfg_half;
  logic [TIME_W-1:0]  win_time [DEPTH];
  kind_t              win_kind [DEPTH];
  int unsigned        win_head;
  int unsigned        win_fill;
  logic [TIME_W-1:0]  last_time;
  logic [FAULT_W-1:0] sticky_fault;

  result_t     pending_intervals [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  bit          cfg_open = 1'b0;

  function automatic void clear_train_model();
    win_head     = 0;
    win_fill     = 0;
    last_time    = '0;
    sticky_fault = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] value);
    case (idx)
      CFG_REF_CLASS:    cfg_ref  = value[CLASS_W-1:0];
      CFG_TARGET_CLASS: cfg_tgt  = value[CLASS_W-1:0];
      CFG_HALF_WINDOW:  cfg_half = value[TIME_W-1:0];
      default: ;
    endcase
  endfunction

  // Walk the history newest first and queue the intervals the event causes.
  function automatic void predict_pairs(input logic [TIME_W-1:0] t,
                                        input logic [CLASS_W-1:0] cls,
                                        input logic end_flag, input bit keep);
    kind_t                   kind;
    kind_t                   sk;
    int unsigned             slot;
    logic [TIME_W-1:0]       old;
    logic signed [IVL_W-1:0] ivls [$];
    result_t                 r;
    if (t < last_time) begin
      sticky_fault[1] = 1'b1;
      if (end_flag) clear_train_model();
      return;
    end
    last_time = t;
    kind = '0;
    if (cls == cfg_ref) kind[KIND_REF] = 1'b1;
    if (cls == cfg_tgt) kind[KIND_TGT] = 1'b1;
    if (kind != '0) begin
      for (int unsigned k = 0; k < win_fill; k++) begin
        slot = (win_head + DEPTH - 1 - k) % DEPTH;
        old  = win_time[slot];
        sk   = win_kind[slot];
        if (t - old > cfg_half) break;
        if (sk[KIND_REF] && kind[KIND_TGT]) ivls.push_back({1'b0, t} - {1'b0, old});
        if (kind[KIND_REF] && sk[KIND_TGT]) ivls.push_back({1'b0, old} - {1'b0, t});
      end
      // evicting an entry still inside the window loses a pair
      if (win_fill == DEPTH) begin
        if (t - win_time[win_head] <= cfg_half) sticky_fault[0] = 1'b1;
      end else begin
        win_fill++;
      end
      win_time[win_head] = t;
      win_kind[win_head] = kind;
      win_head = (win_head + 1) % DEPTH;
    end
    if (keep) begin
      foreach (ivls[i]) begin
        r.interval = ivls[i];
        r.run_last = (i == ivls.size() - 1);
        r.fault    = sticky_fault;
        pending_intervals.push_back(r);
      end
    end
    if (end_flag) clear_train_model();
  endfunction

  function automatic stim_row_t ev_row(input logic [TIME_W-1:0] ts,
                                       input logic [CLASS_W-1:0] cls, input logic end_flag,
                                       input int n, input logic signed [IVL_W-1:0] ivl,
                                       input logic [FAULT_W-1:0] flt);
    stim_row_t row;
    row.op          = ROW_EVT;
    row.idx         = '0;
    row.value       = ts;
    row.cls         = cls;
    row.end_flag    = end_flag;
    row.typed_n     = n;
    row.typed_ivl   = ivl;
    row.typed_fault = flt;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] value);
    stim_row_t row;
    row = ev_row(value, '0, 1'b0, 0, '0, '0);
    row.op  = ROW_CFG;
    row.idx = idx;
    return row;
  endfunction

  function automatic logic [CLASS_W-1:0] pick_class();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return CLASS_W'($urandom_range(1, 8));
      default: return CLASS_W'($urandom);
    endcase
  endfunction

  // Hold off events, wait for the block to go quiet, then write one register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    if (!cfg_open) begin
      evt_if.valid <= 1'b0;
      while (pending_intervals.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    apply_reg(idx, value);
    cfg_open = 1'b1;
  endtask

  task automatic push_event(input logic [TIME_W-1:0] t, input logic [CLASS_W-1:0] cls,
                            input logic end_flag, input int typed_n,
                            input logic signed [IVL_W-1:0] typed_ivl,
                            input logic [FAULT_W-1:0] typed_fault);
    result_t r;
    if (cfg_open) begin
      cfg_we_i <= 1'b0;
      cfg_open = 1'b0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      evt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt_if.valid       <= 1'b1;
    evt_if.event_time  <= t;
    evt_if.event_class <= cls;
    evt_if.train_end   <= end_flag;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    predict_pairs(t, cls, end_flag, typed_n == PREDICTED);
    for (int i = 0; i < typed_n; i++) begin
      r.interval = typed_ivl;
      r.run_last = (i == typed_n - 1);
      r.fault    = typed_fault;
      pending_intervals.push_back(r);
    end
  endtask

  // result side: check each transaction, then stall at random
  initial begin
    result_t want;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (pending_intervals.size() == 0) begin
          $error("result with no expectation waiting: interval %0d", res_if.interval);
          mismatch_count++;
        end else begin
          want = pending_intervals.pop_front();
          if (res_if.interval !== want.interval) begin
            $error("interval: expected %0d, got %0d", want.interval, res_if.interval);
            mismatch_count++;
          end
          if (res_if.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, res_if.run_last);
            mismatch_count++;
          end
          if (res_if.fault !== want.fault) begin
            $error("fault: expected %0d, got %0d", want.fault, res_if.fault);
            mismatch_count++;
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_windowed_event_interval_pairs_core NOT OK");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0]  t;
    logic [TIME_W:0]    sum;
    logic [CLASS_W-1:0] ref_pick;
    logic [CLASS_W-1:0] tgt_pick;
    logic [CLASS_W-1:0] cls;
    logic [TIME_W-1:0]  hw;
    int unsigned        inc;
    int unsigned        sel;
    bit                 dense;

    evt_if.valid       = 1'b0;
    evt_if.event_time  = '0;
    evt_if.event_class = '0;
    evt_if.train_end   = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_data_i         = '0;
    rst_ni             = 1'b0;
    cfg_ref            = '0;
    cfg_tgt            = '0;
    cfg_half           = '0;
    clear_train_model();

    // reset registers: every class 0 is both reference and target, zero window
    directed_rows.push_back(ev_row(32'd0, 16'd0, 1'b0, 0, '0, '0));
    directed_rows.push_back(ev_row(32'd0, 16'd0, 1'b0, 2, '0, '0));
    directed_rows.push_back(ev_row(32'd5, 16'd0, 1'b0, 0, '0, '0));
    // backward timestamp: dropped, sets the order fault
    directed_rows.push_back(ev_row(32'd3, 16'd0, 1'b0, 0, '0, '0));
    directed_rows.push_back(ev_row(32'd5, 16'd0, 1'b1, 2, '0, 2'b10));
    // upper data bits of a class register are dropped; spare index ignored
    directed_rows.push_back(reg_row(CFG_REF_CLASS, 32'hFFFF_0007));
    directed_rows.push_back(reg_row(CFG_TARGET_CLASS, 32'd9));
    directed_rows.push_back(reg_row(CFG_HALF_WINDOW, 32'hFFFF_FFFF));
    directed_rows.push_back(reg_row(CFG_IDX_SPARE, 32'd5));
    // widest intervals both ways
    directed_rows.push_back(ev_row(32'd0, 16'd7, 1'b0, 0, '0, '0));
    directed_rows.push_back(ev_row(32'hFFFF_FFFF, 16'd9, 1'b1, 1, 33'h0_FFFF_FFFF, '0));
    directed_rows.push_back(ev_row(32'd0, 16'd9, 1'b0, 0, '0, '0));
    directed_rows.push_back(ev_row(32'hFFFF_FFFF, 16'd7, 1'b1, 1, 33'h1_0000_0001, '0));
    // other class moves the clock on; backward event with train end still clears
    directed_rows.push_back(ev_row(32'd100, 16'd5, 1'b0, PREDICTED, '0, '0));
    directed_rows.push_back(ev_row(32'd50, 16'd7, 1'b0, PREDICTED, '0, '0));
    directed_rows.push_back(ev_row(32'd120, 16'd9, 1'b0, PREDICTED, '0, '0));
    directed_rows.push_back(ev_row(32'd130, 16'd7, 1'b0, PREDICTED, '0, '0));
    directed_rows.push_back(ev_row(32'd40, 16'd9, 1'b1, PREDICTED, '0, '0));
    directed_rows.push_back(ev_row(32'd0, 16'd9, 1'b0, PREDICTED, '0, '0));
    directed_rows.push_back(ev_row(32'd1, 16'd7, 1'b0, PREDICTED, '0, '0));
    // top class as both roles, inclusive window edge
    directed_rows.push_back(reg_row(CFG_REF_CLASS, 32'h0000_FFFF));
    directed_rows.push_back(reg_row(CFG_TARGET_CLASS, 32'hFFFF_FFFF));
    directed_rows.push_back(reg_row(CFG_HALF_WINDOW, 32'd1000));
    directed_rows.push_back(ev_row(32'd10, 16'hFFFF, 1'b0, PREDICTED, '0, '0));
    directed_rows.push_back(ev_row(32'd10, 16'hFFFF, 1'b0, PREDICTED, '0, '0));
    directed_rows.push_back(ev_row(32'd1010, 16'hFFFF, 1'b0, PREDICTED, '0, '0));
    directed_rows.push_back(ev_row(32'd2011, 16'hFFFF, 1'b0, PREDICTED, '0, '0));
    directed_rows.push_back(ev_row(32'd2011, 16'd0, 1'b1, PREDICTED, '0, '0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CFG) begin
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        push_event(directed_rows[i].value, directed_rows[i].cls, directed_rows[i].end_flag,
                   directed_rows[i].typed_n, directed_rows[i].typed_ivl,
                   directed_rows[i].typed_fault);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      // dense phases fill the history with one class inside a wide window
      dense    = (p % 4 == 1);
      ref_pick = pick_class();
      tgt_pick = (dense || $urandom_range(2) == 0) ? ref_pick : pick_class();
      case ($urandom_range(3))
        0:       hw = '0;
        1:       hw = '1;
        2:       hw = TIME_W'($urandom_range(200));
        default: hw = TIME_W'($urandom);
      endcase
      if (dense) hw = $urandom_range(1) ? '1 : 32'd5000;
      write_reg(CFG_REF_CLASS, {16'($urandom), ref_pick});
      write_reg(CFG_TARGET_CLASS, {16'($urandom), tgt_pick});
      write_reg(CFG_HALF_WINDOW, hw);
      if (p == 5) write_reg(CFG_IDX_SPARE, $urandom);
      case (p % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 55; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 55; end
        default: begin src_idle_pct = 13; snk_stall_pct = 13; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(9);
        if (sel < 4) cls = ref_pick;
        else if (sel < 8) cls = tgt_pick;
        else cls = CLASS_W'($urandom);

        if (last_time != 0 && $urandom_range(11) == 0) begin
          t = TIME_W'($urandom_range(last_time - 1));
        end else if ($urandom_range(29) == 0) begin
          t = $urandom;
        end else if (last_time == 0) begin
          t = ($urandom_range(2) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(1000));
        end else begin
          if (dense || $urandom_range(1) == 1) inc = $urandom_range(3);
          else inc = $urandom_range(300);
          sum = {1'b0, last_time} + (TIME_W + 1)'(inc);
          t = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end
        push_event(t, cls, ($urandom_range(19) == 0), PREDICTED, '0, '0);
      end
    end

    if (cfg_open) cfg_we_i <= 1'b0;
    evt_if.valid <= 1'b0;
    while (pending_intervals.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_windowed_event_interval_pairs_core OK");
    end else begin
      $display("tb_windowed_event_interval_pairs_core NOT OK");
    end
    $finish;
  end

endmodule
